// ===== rtl/npst_pkg.sv =====
// Package for the NAND page state tracker: shared types, codes and reset values.
// Used by npst_cfg_regs and nand_page_state_tracker; depends on nothing else.
`default_nettype none

package npst_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PROGRAM        = 3'd0,
        OP_READ           = 3'd1,
        OP_ERASE          = 3'd2,
        OP_INVALIDATE     = 3'd3,
        OP_PAGE_QUERY     = 3'd4,
        OP_BLOCK_QUERY    = 3'd5,
        OP_COUNTER_READ   = 3'd6,
        OP_RESET_COUNTERS = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        SEL_PROGRAMS  = 3'd0,
        SEL_READS     = 3'd1,
        SEL_ERASES    = 3'd2,
        SEL_TIME      = 3'd3,
        SEL_MAX_ERASE = 3'd4,
        SEL_ERASE_SUM = 3'd5
    } t_cnt_sel;

    typedef enum logic [2:0] {
        REG_BLOCKS_IN_USE   = 3'd0,
        REG_PAGES_IN_USE    = 3'd1,
        REG_PROGRAM_LATENCY = 3'd2,
        REG_READ_LATENCY    = 3'd3,
        REG_ERASE_LATENCY   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ERASE,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ACC_COUNT,
        ACC_TIME,
        ACC_BLOCK,
        ACC_SUM
    } t_acc;

    typedef struct packed {
        logic [10:0] blocks_in_use;
        logic [8:0]  pages_in_use;
        logic [23:0] program_latency;
        logic [23:0] read_latency;
        logic [23:0] erase_latency;
    } t_cfg;

    typedef struct packed {
        logic [63:0] prog;
        logic [63:0] valid;
    } t_pg_word;

    typedef struct packed {
        logic [31:0] erase_cnt;
        logic [8:0]  invalid_count;
    } t_blk_entry;

    localparam logic [10:0] RST_BLOCKS_IN_USE   = 11'd1024;
    localparam logic [8:0]  RST_PAGES_IN_USE    = 9'd256;
    localparam logic [23:0] RST_PROGRAM_LATENCY = 24'd256000;
    localparam logic [23:0] RST_READ_LATENCY    = 24'd12800;
    localparam logic [23:0] RST_ERASE_LATENCY   = 24'd1280000;

endpackage

`default_nettype wire

// ===== rtl/npst_cfg_regs.sv =====
// Configuration register file behind the APB-style port of the page state tracker.
// Depends on npst_pkg for the register indexes, reset values and the t_cfg bundle.
`default_nettype none

module npst_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [npst_pkg::ADDR_W-1:0] paddr,
    input  wire logic [npst_pkg::DATA_W-1:0] pwdata,
    output logic      [npst_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output npst_pkg::t_cfg                  o_cfg
);
    import npst_pkg::*;

    t_cfg         r_cfg;
    t_cfg         n_cfg;
    logic [2:0]   reg_idx;
    logic         wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_BLOCKS_IN_USE:   n_cfg.blocks_in_use   = pwdata[10:0];
                REG_PAGES_IN_USE:    n_cfg.pages_in_use    = pwdata[8:0];
                REG_PROGRAM_LATENCY: n_cfg.program_latency = pwdata[23:0];
                REG_READ_LATENCY:    n_cfg.read_latency    = pwdata[23:0];
                REG_ERASE_LATENCY:   n_cfg.erase_latency   = pwdata[23:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BLOCKS_IN_USE:   prdata = {21'd0, r_cfg.blocks_in_use};
            REG_PAGES_IN_USE:    prdata = {23'd0, r_cfg.pages_in_use};
            REG_PROGRAM_LATENCY: prdata = {8'd0, r_cfg.program_latency};
            REG_READ_LATENCY:    prdata = {8'd0, r_cfg.read_latency};
            REG_ERASE_LATENCY:   prdata = {8'd0, r_cfg.erase_latency};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blocks_in_use   <= RST_BLOCKS_IN_USE;
            r_cfg.pages_in_use    <= RST_PAGES_IN_USE;
            r_cfg.program_latency <= RST_PROGRAM_LATENCY;
            r_cfg.read_latency    <= RST_READ_LATENCY;
            r_cfg.erase_latency   <= RST_ERASE_LATENCY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nand_page_state_tracker.sv =====
// NAND page state tracker: page flag memory, block count memory, telemetry counters.
// Commands pass S_READ, S_EXEC and S_DONE; program, read, erase and an invalidate that
// clears a flag also use S_ACC, erase after clearing its rows in S_ERASE. S_DONE
// registers the result, waiting while the output stalls. One command at a time: the
// next is taken in the cycle after its result is registered, limited by the single
// shared 64-bit adder and one memory write port. Reset runs a clearing pass, stall high.
`default_nettype none

module nand_page_state_tracker #(
    parameter int BLOCKS        = 1024,
    parameter int PAGES_PER_BLK = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [9:0]                  i_block_index,
    input  wire logic [7:0]                  i_page_index,
    input  wire logic [2:0]                  i_counter_select,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_ok,
    output logic                             o_page_programmed,
    output logic                             o_page_valid,
    output logic [31:0]                      o_erase_count,
    output logic [8:0]                       o_invalid_count,
    output logic [63:0]                      o_value,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [npst_pkg::ADDR_W-1:0] paddr,
    input  wire logic [npst_pkg::DATA_W-1:0] pwdata,
    output logic      [npst_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import npst_pkg::*;

    localparam int WPB    = (PAGES_PER_BLK + 63) / 64;
    localparam int ROWS   = BLOCKS * WPB;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLK_AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int WPB_W  = (WPB > 1) ? $clog2(WPB) : 1;

    t_cfg cfg;

    npst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_pg_word   r_pg_mem  [ROWS];
    t_blk_entry r_blk_mem [BLOCKS];
    t_pg_word   r_pg_rd;
    t_blk_entry r_blk_rd;

    t_state              r_state,     n_state;
    t_opcode             r_op,        n_op;
    logic [9:0]          r_blk,       n_blk;
    logic [7:0]          r_pg,        n_pg;
    logic [2:0]          r_sel,       n_sel;
    logic                r_bok,       n_bok;
    logic                r_pok,       n_pok;
    logic [ROW_AW-1:0]   r_base,      n_base;
    logic [ROW_AW-1:0]   r_row,       n_row;
    logic [WPB_W-1:0]    r_erow,      n_erow;
    logic [ROW_AW-1:0]   r_clr,       n_clr;
    t_acc                r_step,      n_step;
    logic                r_ok,        n_ok;
    logic                r_prog_bit,  n_prog_bit;
    logic                r_valid_bit, n_valid_bit;
    logic [31:0]         r_ec,        n_ec;
    logic [8:0]          r_inv,       n_inv;
    logic [63:0]         r_value,     n_value;
    logic [63:0]         r_programs,  n_programs;
    logic [63:0]         r_reads,     n_reads;
    logic [63:0]         r_erases,    n_erases;
    logic [63:0]         r_time,      n_time;
    logic [31:0]         r_max,       n_max;
    logic [63:0]         r_sum,       n_sum;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok,    n_out_ok;
    logic                r_out_prog,  n_out_prog;
    logic                r_out_vld,   n_out_vld;
    logic [31:0]         r_out_ec,    n_out_ec;
    logic [8:0]          r_out_inv,   n_out_inv;
    logic [63:0]         r_out_value, n_out_value;

    logic [31:0]         in_blk32;
    logic [31:0]         in_pg32;
    logic                in_bok;
    logic                in_pok;
    logic [31:0]         in_base32;
    logic [31:0]         in_row32;
    logic [31:0]         blk32;
    logic [BLK_AW-1:0]   blk_addr;
    logic [31:0]         erow32;
    logic [63:0]         acc_a;
    logic [63:0]         acc_b;
    logic [63:0]         acc_sum;
    logic                page_op;
    logic                block_op;

    logic                pg_we;
    logic [ROW_AW-1:0]   pg_wa;
    t_pg_word            pg_wd;
    logic                blk_we;
    logic [BLK_AW-1:0]   blk_wa;
    t_blk_entry          blk_wd;

    assign in_blk32  = {22'd0, i_block_index};
    assign in_pg32   = {24'd0, i_page_index};
    assign in_bok    = (in_blk32 < {21'd0, cfg.blocks_in_use}) && (in_blk32 < 32'(BLOCKS));
    assign in_pok    = in_bok && (in_pg32 < {23'd0, cfg.pages_in_use})
                       && (in_pg32 < 32'(PAGES_PER_BLK));
    assign in_base32 = in_blk32 * 32'(WPB);
    assign in_row32  = in_base32 + {30'd0, i_page_index[7:6]};
    assign blk32     = {22'd0, r_blk};
    assign blk_addr  = blk32[BLK_AW-1:0];
    assign erow32    = 32'(r_base) + 32'(r_erow);
    assign page_op   = (r_op == OP_PROGRAM) || (r_op == OP_READ) || (r_op == OP_ERASE)
                       || (r_op == OP_INVALIDATE) || (r_op == OP_PAGE_QUERY);
    assign block_op  = page_op || (r_op == OP_BLOCK_QUERY);

    // Operand selection for the shared adder.
    always_comb begin
        acc_a = '0;
        acc_b = 64'd1;
        case (r_step)
            ACC_COUNT: begin
                case (r_op)
                    OP_PROGRAM: acc_a = r_programs;
                    OP_READ:    acc_a = r_reads;
                    default:    acc_a = r_erases;
                endcase
            end
            ACC_TIME: begin
                acc_a = r_time;
                case (r_op)
                    OP_PROGRAM: acc_b = {40'd0, cfg.program_latency};
                    OP_READ:    acc_b = {40'd0, cfg.read_latency};
                    default:    acc_b = {40'd0, cfg.erase_latency};
                endcase
            end
            ACC_BLOCK: begin
                if (r_op == OP_ERASE) begin
                    acc_a = {32'd0, r_ec};
                end else begin
                    acc_a = {55'd0, r_inv};
                end
            end
            ACC_SUM: acc_a = r_sum;
            default: acc_a = '0;
        endcase
    end

    assign acc_sum = acc_a + acc_b;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_blk       = r_blk;
        n_pg        = r_pg;
        n_sel       = r_sel;
        n_bok       = r_bok;
        n_pok       = r_pok;
        n_base      = r_base;
        n_row       = r_row;
        n_erow      = r_erow;
        n_clr       = r_clr;
        n_step      = r_step;
        n_ok        = r_ok;
        n_prog_bit  = r_prog_bit;
        n_valid_bit = r_valid_bit;
        n_ec        = r_ec;
        n_inv       = r_inv;
        n_value     = r_value;
        n_programs  = r_programs;
        n_reads     = r_reads;
        n_erases    = r_erases;
        n_time      = r_time;
        n_max       = r_max;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_ok    = r_out_ok;
        n_out_prog  = r_out_prog;
        n_out_vld   = r_out_vld;
        n_out_ec    = r_out_ec;
        n_out_inv   = r_out_inv;
        n_out_value = r_out_value;
        pg_we       = 1'b0;
        pg_wa       = r_row;
        pg_wd       = r_pg_rd;
        blk_we      = 1'b0;
        blk_wa      = blk_addr;
        blk_wd      = '0;

        case (r_state)
            S_CLEAR: begin
                pg_we = 1'b1;
                pg_wa = r_clr;
                pg_wd = '0;
                if (32'(r_clr) < 32'(BLOCKS)) begin
                    blk_we = 1'b1;
                    blk_wa = r_clr[BLK_AW-1:0];
                end
                if (32'(r_clr) == 32'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + ROW_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_opcode'(i_opcode);
                    n_blk   = i_block_index;
                    n_pg    = i_page_index;
                    n_sel   = i_counter_select;
                    n_bok   = in_bok;
                    n_pok   = in_pok;
                    n_base  = in_base32[ROW_AW-1:0];
                    n_row   = in_row32[ROW_AW-1:0];
                    n_erow  = '0;
                    n_ok    = 1'b0;
                    n_value = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_prog_bit  = r_pg_rd.prog[r_pg[5:0]];
                n_valid_bit = r_pg_rd.valid[r_pg[5:0]];
                n_ec        = r_blk_rd.erase_cnt;
                n_inv       = r_blk_rd.invalid_count;
                n_step      = ACC_COUNT;
                n_state     = S_DONE;
                case (r_op)
                    OP_PROGRAM: begin
                        if (r_pok && !r_pg_rd.prog[r_pg[5:0]]) begin
                            pg_we                    = 1'b1;
                            pg_wd.prog[r_pg[5:0]]    = 1'b1;
                            pg_wd.valid[r_pg[5:0]]   = 1'b1;
                            n_prog_bit               = 1'b1;
                            n_valid_bit              = 1'b1;
                            n_ok                     = 1'b1;
                            n_state                  = S_ACC;
                        end
                    end
                    OP_READ: begin
                        if (r_pok) begin
                            n_ok    = 1'b1;
                            n_state = S_ACC;
                        end
                    end
                    OP_ERASE: begin
                        if (r_bok) begin
                            n_ok        = 1'b1;
                            n_prog_bit  = 1'b0;
                            n_valid_bit = 1'b0;
                            n_state     = S_ERASE;
                        end
                    end
                    OP_INVALIDATE: begin
                        if (r_pok) begin
                            n_ok = 1'b1;
                            if (r_pg_rd.valid[r_pg[5:0]]) begin
                                pg_we                  = 1'b1;
                                pg_wd.valid[r_pg[5:0]] = 1'b0;
                                n_valid_bit            = 1'b0;
                                n_step                 = ACC_BLOCK;
                                n_state                = S_ACC;
                            end
                        end
                    end
                    OP_PAGE_QUERY: begin
                        n_ok = r_pok;
                    end
                    OP_BLOCK_QUERY: begin
                        n_ok = r_bok;
                    end
                    OP_COUNTER_READ: begin
                        n_ok = 1'b1;
                        case (r_sel)
                            SEL_PROGRAMS:  n_value = r_programs;
                            SEL_READS:     n_value = r_reads;
                            SEL_ERASES:    n_value = r_erases;
                            SEL_TIME:      n_value = r_time;
                            SEL_MAX_ERASE: n_value = {32'd0, r_max};
                            SEL_ERASE_SUM: n_value = r_sum;
                            default:       n_ok    = 1'b0;
                        endcase
                    end
                    OP_RESET_COUNTERS: begin
                        n_ok       = 1'b1;
                        n_programs = '0;
                        n_reads    = '0;
                        n_erases   = '0;
                        n_time     = '0;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ERASE: begin
                pg_we = 1'b1;
                pg_wa = erow32[ROW_AW-1:0];
                pg_wd = '0;
                if (32'(r_erow) == 32'(WPB - 1)) begin
                    n_step  = ACC_COUNT;
                    n_state = S_ACC;
                end else begin
                    n_erow = r_erow + WPB_W'(1);
                end
            end
            S_ACC: begin
                case (r_step)
                    ACC_COUNT: begin
                        case (r_op)
                            OP_PROGRAM: n_programs = acc_sum;
                            OP_READ:    n_reads    = acc_sum;
                            default:    n_erases   = acc_sum;
                        endcase
                        n_step = ACC_TIME;
                    end
                    ACC_TIME: begin
                        n_time = acc_sum;
                        if (r_op == OP_ERASE) begin
                            n_step = ACC_BLOCK;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    ACC_BLOCK: begin
                        blk_we = 1'b1;
                        if (r_op == OP_ERASE) begin
                            n_ec                 = acc_sum[31:0];
                            n_inv                = '0;
                            blk_wd.erase_cnt     = acc_sum[31:0];
                            blk_wd.invalid_count = '0;
                            if (acc_sum[31:0] > r_max) begin
                                n_max = acc_sum[31:0];
                            end
                            n_step = ACC_SUM;
                        end else begin
                            n_inv                = acc_sum[8:0];
                            blk_wd.erase_cnt     = r_ec;
                            blk_wd.invalid_count = acc_sum[8:0];
                            n_state              = S_DONE;
                        end
                    end
                    ACC_SUM: begin
                        n_sum   = acc_sum;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_prog  = page_op && r_pok && r_prog_bit;
                    n_out_vld   = page_op && r_pok && r_valid_bit;
                    n_out_ec    = (block_op && r_bok) ? r_ec : 32'd0;
                    n_out_inv   = (block_op && r_bok) ? r_inv : 9'd0;
                    n_out_value = r_value;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            r_pg_mem[pg_wa] <= pg_wd;
        end
        r_pg_rd <= r_pg_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_wa] <= blk_wd;
        end
        r_blk_rd <= r_blk_mem[blk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= ACC_COUNT;
            r_programs  <= '0;
            r_reads     <= '0;
            r_erases    <= '0;
            r_time      <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_step      <= n_step;
            r_programs  <= n_programs;
            r_reads     <= n_reads;
            r_erases    <= n_erases;
            r_time      <= n_time;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_blk       <= n_blk;
        r_pg        <= n_pg;
        r_sel       <= n_sel;
        r_bok       <= n_bok;
        r_pok       <= n_pok;
        r_base      <= n_base;
        r_row       <= n_row;
        r_erow      <= n_erow;
        r_ok        <= n_ok;
        r_prog_bit  <= n_prog_bit;
        r_valid_bit <= n_valid_bit;
        r_ec        <= n_ec;
        r_inv       <= n_inv;
        r_value     <= n_value;
        r_out_ok    <= n_out_ok;
        r_out_prog  <= n_out_prog;
        r_out_vld   <= n_out_vld;
        r_out_ec    <= n_out_ec;
        r_out_inv   <= n_out_inv;
        r_out_value <= n_out_value;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_out_ok;
    assign o_page_programmed = r_out_prog;
    assign o_page_valid      = r_out_vld;
    assign o_erase_count     = r_out_ec;
    assign o_invalid_count   = r_out_inv;
    assign o_value           = r_out_value;

endmodule

`default_nettype wire

// ===== rtl/npst_chk.sv =====
// Port-level checker for nand_page_state_tracker and the bind that attaches it.
// Sees only the top-level ports; depends on no package.
`default_nettype none

module npst_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_ok,
    input wire logic        o_page_programmed,
    input wire logic        o_page_valid,
    input wire logic [31:0] o_erase_count,
    input wire logic [8:0]  o_invalid_count,
    input wire logic [63:0] o_value
);

    a_valid_needs_programmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_page_valid |-> o_page_programmed)
        else $error("page reported valid but not programmed");

    a_value_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_value != 64'd0) |-> o_ok)
        else $error("nonzero counter value on a failed transaction");

    a_invalid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_invalid_count <= 9'd256))
        else $error("invalid page count above pages per block");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_erase_count))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("reset did not clear output and start clearing pass");

endmodule

bind nand_page_state_tracker npst_chk u_npst_chk (.*);

`default_nettype wire

// ===== verif/tb_nand_page_state_tracker.sv =====
// Self-checking testbench for nand_page_state_tracker: it drives commands and register writes,
// predicts every result from its own model of page flags, block counts and telemetry counters.
// Depends on npst_pkg and the nand_page_state_tracker RTL only.
`default_nettype none

module tb_nand_page_state_tracker;
    import npst_pkg::*;

    localparam int NUM_BLOCKS      = 1024;
    localparam int PAGES_PER_BLK   = 256;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic        ok;
        logic        page_programmed;
        logic        pg_valid;
        logic [31:0] erase_cnt;
        logic [8:0]  invalid_count;
        logic [63:0] value;
    } t_tracker_result;

    class page_tracker_scoreboard;
        bit [PAGES_PER_BLK-1:0] programmed_map [NUM_BLOCKS];
        bit [PAGES_PER_BLK-1:0] valid_map [NUM_BLOCKS];
        bit [31:0] erase_counts [NUM_BLOCKS];
        bit [8:0]  invalid_counts [NUM_BLOCKS];
        bit [63:0] programs_total, reads_total, erases_total, time_total, erase_sum;
        bit [31:0] max_erase_seen;

        logic [10:0] blocks_in_use   = RST_BLOCKS_IN_USE;
        logic [8:0]  pages_in_use    = RST_PAGES_IN_USE;
        logic [23:0] program_latency = RST_PROGRAM_LATENCY;
        logic [23:0] read_latency    = RST_READ_LATENCY;
        logic [23:0] erase_latency   = RST_ERASE_LATENCY;

        t_tracker_result pending_results[$];
        int unsigned mismatches;

        function int unsigned blocks_limit();
            return (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : blocks_in_use;
        endfunction

        function int unsigned pages_limit();
            return (pages_in_use > PAGES_PER_BLK) ? PAGES_PER_BLK : pages_in_use;
        endfunction

        function void apply_register(t_reg_idx idx, logic [31:0] data);
            case (idx)
                REG_BLOCKS_IN_USE:   blocks_in_use   = data[10:0];
                REG_PAGES_IN_USE:    pages_in_use    = data[8:0];
                REG_PROGRAM_LATENCY: program_latency = data[23:0];
                REG_READ_LATENCY:    read_latency    = data[23:0];
                REG_ERASE_LATENCY:   erase_latency   = data[23:0];
                default: ;
            endcase
        endfunction

        function void note_command(t_opcode op, logic [9:0] blk, logic [7:0] pg,
                                   logic [2:0] sel);
            t_tracker_result r;
            bit blk_in, pg_in;
            r = '{default: '0};
            blk_in = blk < blocks_limit();
            pg_in = blk_in && (pg < pages_limit());
            case (op)
                OP_PROGRAM: begin
                    if (pg_in && !programmed_map[blk][pg]) begin
                        programmed_map[blk][pg] = 1'b1;
                        valid_map[blk][pg] = 1'b1;
                        programs_total++;
                        time_total += 64'(program_latency);
                        r.ok = 1'b1;
                    end
                end
                OP_READ: begin
                    if (pg_in) begin
                        reads_total++;
                        time_total += 64'(read_latency);
                        r.ok = 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (blk_in) begin
                        programmed_map[blk] = '0;
                        valid_map[blk] = '0;
                        invalid_counts[blk] = '0;
                        erase_counts[blk]++;
                        if (erase_counts[blk] > max_erase_seen) begin
                            max_erase_seen = erase_counts[blk];
                        end
                        erase_sum++;
                        erases_total++;
                        time_total += 64'(erase_latency);
                        r.ok = 1'b1;
                    end
                end
                OP_INVALIDATE: begin
                    if (pg_in) begin
                        if (valid_map[blk][pg]) begin
                            valid_map[blk][pg] = 1'b0;
                            invalid_counts[blk]++;
                        end
                        r.ok = 1'b1;
                    end
                end
                OP_PAGE_QUERY:  r.ok = pg_in;
                OP_BLOCK_QUERY: r.ok = blk_in;
                OP_COUNTER_READ: begin
                    r.ok = 1'b1;
                    case (sel)
                        SEL_PROGRAMS:  r.value = programs_total;
                        SEL_READS:     r.value = reads_total;
                        SEL_ERASES:    r.value = erases_total;
                        SEL_TIME:      r.value = time_total;
                        SEL_MAX_ERASE: r.value = 64'(max_erase_seen);
                        SEL_ERASE_SUM: r.value = erase_sum;
                        default:       r.ok = 1'b0;
                    endcase
                end
                default: begin
                    programs_total = '0;
                    reads_total = '0;
                    erases_total = '0;
                    time_total = '0;
                    r.ok = 1'b1;
                end
            endcase
            if (op <= OP_PAGE_QUERY && pg_in) begin
                r.page_programmed = programmed_map[blk][pg];
                r.pg_valid = valid_map[blk][pg];
            end
            if (op <= OP_BLOCK_QUERY && blk_in) begin
                r.erase_cnt = erase_counts[blk];
                r.invalid_count = invalid_counts[blk];
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
            if (expected !== actual) begin
                $error("%s: expected %0h, actual %0h", name, expected, actual);
                mismatches++;
            end
        endfunction

        function void check_result(t_tracker_result got);
            t_tracker_result exp;
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with no command outstanding");
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            compare_field("o_ok", 64'(exp.ok), 64'(got.ok));
            compare_field("o_page_programmed", 64'(exp.page_programmed),
                          64'(got.page_programmed));
            compare_field("o_page_valid", 64'(exp.pg_valid), 64'(got.pg_valid));
            compare_field("o_erase_count", 64'(exp.erase_cnt), 64'(got.erase_cnt));
            compare_field("o_invalid_count", 64'(exp.invalid_count), 64'(got.invalid_count));
            compare_field("o_value", exp.value, got.value);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_opcode;
    logic [9:0]        i_block_index;
    logic [7:0]        i_page_index;
    logic [2:0]        i_counter_select;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_ok;
    logic              o_page_programmed;
    logic              o_page_valid;
    logic [31:0]       o_erase_count;
    logic [8:0]        o_invalid_count;
    logic [63:0]       o_value;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    page_tracker_scoreboard sb;
    bit quiet_tail;
    bit stall_hold_request;
    int unsigned idle_cycles;

    nand_page_state_tracker uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_block_index     (i_block_index),
        .i_page_index      (i_page_index),
        .i_counter_select  (i_counter_select),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_ok              (o_ok),
        .o_page_programmed (o_page_programmed),
        .o_page_valid      (o_page_valid),
        .o_erase_count     (o_erase_count),
        .o_invalid_count   (o_invalid_count),
        .o_value           (o_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        bit moved;
        t_tracker_result got;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_command(t_opcode'(i_opcode), i_block_index, i_page_index,
                                i_counter_select);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got.ok = o_ok;
                got.page_programmed = o_page_programmed;
                got.pg_valid = o_page_valid;
                got.erase_cnt = o_erase_count;
                got.invalid_count = o_invalid_count;
                got.value = o_value;
                sb.check_result(got);
                moved = 1'b1;
            end
        end
        if (moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : result_stall_driver
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (stall_hold_request) begin
                stall_hold_request = 1'b0;
                i_out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(3) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
                repeat ($urandom_range(1, 24)) @(negedge i_clk);
            end
        end
    end

    task automatic issue_command(t_opcode op, logic [9:0] blk, logic [7:0] pg,
                                 logic [2:0] sel);
        int unsigned gap;
        if (!quiet_tail && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_opcode = op;
        i_block_index = blk;
        i_page_index = pg;
        i_counter_select = sel;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic int unsigned pick_index(int unsigned lim, int unsigned top,
                                               int unsigned hot);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(99);
        if (r < 55) begin
            return $urandom_range(hot);
        end
        if (r < 80 && lim != 0) begin
            v = lim - 1 + $urandom_range(2);
            return (v > top) ? top : v;
        end
        return $urandom_range(top);
    endfunction

    task automatic issue_random_command();
        int unsigned r;
        t_opcode op;
        r = $urandom_range(99);
        if (r < 28) op = OP_PROGRAM;
        else if (r < 42) op = OP_READ;
        else if (r < 48) op = OP_ERASE;
        else if (r < 66) op = OP_INVALIDATE;
        else if (r < 76) op = OP_PAGE_QUERY;
        else if (r < 84) op = OP_BLOCK_QUERY;
        else if (r < 96) op = OP_COUNTER_READ;
        else op = OP_RESET_COUNTERS;
        issue_command(op, 10'(pick_index(sb.blocks_limit(), 1023, 3)),
                      8'(pick_index(sb.pages_limit(), 255, 7)), 3'($urandom_range(7)));
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, int unsigned width, logic [31:0] val);
        logic [31:0] data;
        data = val | ($urandom() << width);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.apply_register(idx, data);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_phase(int unsigned blocks, int unsigned pages, int unsigned prog_lat,
                             int unsigned read_lat, int unsigned erase_lat,
                             int unsigned count, bit with_hold_off);
        settle();
        write_register(REG_BLOCKS_IN_USE, 11, blocks);
        write_register(REG_PAGES_IN_USE, 9, pages);
        write_register(REG_PROGRAM_LATENCY, 24, prog_lat);
        write_register(REG_READ_LATENCY, 24, read_lat);
        write_register(REG_ERASE_LATENCY, 24, erase_lat);
        for (int unsigned n = 0; n < count; n++) begin
            if (with_hold_off && n == count / 2) begin
                stall_hold_request = 1'b1;
            end
            issue_random_command();
        end
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_PROGRAM;
        i_block_index = '0;
        i_page_index = '0;
        i_counter_select = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_command(OP_PAGE_QUERY, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_PROGRAM, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_PROGRAM, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_READ, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_INVALIDATE, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_INVALIDATE, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_BLOCK_QUERY, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_PROGRAM, 10'd1023, 8'd255, SEL_PROGRAMS);
        issue_command(OP_READ, 10'd1023, 8'd200, SEL_PROGRAMS);
        issue_command(OP_PAGE_QUERY, 10'd1023, 8'd255, SEL_PROGRAMS);
        issue_command(OP_ERASE, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_ERASE, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_PAGE_QUERY, 10'd0, 8'd0, SEL_PROGRAMS);
        for (int s = 0; s < 8; s++) begin
            issue_command(OP_COUNTER_READ, 10'd0, 8'd0, 3'(s));
        end
        issue_command(OP_RESET_COUNTERS, 10'd0, 8'd0, SEL_PROGRAMS);
        issue_command(OP_COUNTER_READ, 10'd0, 8'd0, SEL_TIME);
        issue_command(OP_COUNTER_READ, 10'd0, 8'd0, SEL_MAX_ERASE);

        run_phase(8, 16, $urandom_range(16777215), $urandom_range(16777215),
                  $urandom_range(16777215), 400, 1'b1);
        run_phase(0, 256, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 60, 1'b0);
        run_phase(2047, 511, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 300, 1'b0);
        run_phase(1, 1, 0, 0, 0, 150, 1'b0);
        run_phase(1024, 0, 1, 1, 1, 60, 1'b0);
        run_phase($urandom_range(2, 40), $urandom_range(65, 130), $urandom_range(16777215),
                  $urandom_range(16777215), $urandom_range(16777215), 250, 1'b0);
        quiet_tail = 1'b1;
        run_phase(4, 70, $urandom_range(16777215), $urandom_range(16777215),
                  $urandom_range(16777215), 280, 1'b0);
        settle();

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
